// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, off during reset
`define LVDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked property, also during reset
`define LVDS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LVDS_ASSERT(lbl, prop, msg)
`define LVDS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/lvds_pkg.sv -----
// ----------------------------------------------------------------------------
// lvds_pkg
// shared widths, register codes, result type and saturation helpers
// ----------------------------------------------------------------------------
package lvds_pkg;

  localparam int CW         = 48;       // coordinate width, Q32.16
  localparam int QW         = CW + 16;  // quotient width of the dividers
  localparam int DW         = 2 * CW;   // product, divisor and remainder width
  localparam int RW         = CW + 2;   // root remainder width
  localparam int SQRT_STEPS = CW;
  localparam int DIV_STEPS  = QW;
  localparam int MUL_LAT    = 2;

  typedef logic [CW-1:0] len_t;
  typedef logic [QW-1:0] quo_t;
  typedef logic [DW-1:0] wide_t;

  typedef enum logic [2:0] {
    CFG_CAM_X,
    CFG_CAM_Y,
    CFG_CAM_Z,
    CFG_PIX_ANGLE,
    CFG_MIN_SIZE,
    CFG_MID_PLANE,
    CFG_SCENE_SCALE,
    CFG_DEPTH_ON
  } cfg_idx_e;

  localparam len_t UMAX = '1;
  localparam len_t SMAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    logic signed [CW-1:0] scene_x;
    logic signed [CW-1:0] scene_y;
    logic signed [CW-1:0] scene_z;
    len_t                 scene_dist;
    len_t                 scale_factor;
    len_t                 obs_distance;
    len_t                 apparent_size;
    logic                 is_resolved;
  } res_t;

  // unsigned saturation of a quotient
  function automatic len_t usat(input quo_t v);
    return (v > QW'(UMAX)) ? UMAX : v[CW-1:0];
  endfunction

  // signed length from sign and magnitude, saturated
  function automatic len_t sout(input logic neg, input quo_t q);
    quo_t lim;
    quo_t v;
    quo_t vn;
    lim = neg ? (QW'(SMAX) + quo_t'(1)) : QW'(SMAX);
    v   = (q > lim) ? lim : q;
    vn  = ~v + quo_t'(1);
    return neg ? vn[CW-1:0] : v[CW-1:0];
  endfunction

endpackage

// ----- hw/rtl/lvds_if.sv -----
// ----------------------------------------------------------------------------
// lvds stream interfaces
// object channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface lvds_obj_if;
  import lvds_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] obj_x;
  logic signed [CW-1:0] obj_y;
  logic signed [CW-1:0] obj_z;
  len_t                 obj_extent;

  modport source (output valid, obj_x, obj_y, obj_z, obj_extent, input ready);
  modport sink   (input valid, obj_x, obj_y, obj_z, obj_extent, output ready);
endinterface

interface lvds_res_if;
  import lvds_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] scene_x;
  logic signed [CW-1:0] scene_y;
  logic signed [CW-1:0] scene_z;
  len_t                 scene_dist;
  len_t                 scale_factor;
  len_t                 obs_distance;
  len_t                 apparent_size;
  logic                 is_resolved;

  modport source (output valid, scene_x, scene_y, scene_z, scene_dist, scale_factor,
                  obs_distance, apparent_size, is_resolved, input ready);
  modport sink   (input valid, scene_x, scene_y, scene_z, scene_dist, scale_factor,
                  obs_distance, apparent_size, is_resolved, output ready);
endinterface

// ----- hw/rtl/lvds_mul.sv -----
// ----------------------------------------------------------------------------
// lvds_mul
// two-stage unsigned multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
module lvds_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  lvds_pkg::len_t a_i,
  input  lvds_pkg::len_t b_i,
  output lvds_pkg::wide_t p_o
);
  import lvds_pkg::*;

  localparam int H = CW / 2;

  logic [CW-1:0] pp_q [4];
  wide_t         p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q[0] <= a_i[H-1:0]  * b_i[H-1:0];
      pp_q[1] <= a_i[H-1:0]  * b_i[CW-1:H];
      pp_q[2] <= a_i[CW-1:H] * b_i[H-1:0];
      pp_q[3] <= a_i[CW-1:H] * b_i[CW-1:H];
      p_q     <= DW'(pp_q[0]) + (DW'(pp_q[1]) << H) + (DW'(pp_q[2]) << H)
               + (DW'(pp_q[3]) << CW);
    end
  end

  assign p_o = p_q;
endmodule

// ----- hw/rtl/lvds_div.sv -----
// ----------------------------------------------------------------------------
// lvds_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lvds_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  lvds_pkg::wide_t rem_i,   // partial remainder, below the divisor
  input  lvds_pkg::quo_t  tail_i,  // remaining dividend bits, msb first
  input  lvds_pkg::wide_t div_i,
  output lvds_pkg::quo_t  quo_o
);
  import lvds_pkg::*;

  wide_t rem_q [DIV_STEPS];
  wide_t div_q [DIV_STEPS];
  quo_t  tq_q  [DIV_STEPS];  // dividend bits shift out, quotient bits shift in

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    wide_t         r_in;
    wide_t         d_in;
    quo_t          t_in;
    logic [DW:0]   sh;
    logic [DW:0]   dif;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = rem_i;
      assign d_in = div_i;
      assign t_in = tail_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = div_q[k-1];
      assign t_in = tq_q[k-1];
    end

    assign sh  = {r_in, t_in[QW-1]};
    assign dif = sh - {1'b0, d_in};
    assign ge  = ~dif[DW];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? dif[DW-1:0] : sh[DW-1:0];
        div_q[k] <= d_in;
        tq_q[k]  <= {t_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = tq_q[DIV_STEPS-1];
endmodule

// ----- hw/rtl/lvds_sqrt.sv -----
// ----------------------------------------------------------------------------
// lvds_sqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module lvds_sqrt (
  input  logic            clk_i,
  input  logic            en_i,
  input  lvds_pkg::wide_t val_i,
  output lvds_pkg::len_t  root_o
);
  import lvds_pkg::*;

  logic [RW-1:0] rem_q  [SQRT_STEPS];
  len_t          root_q [SQRT_STEPS];
  wide_t         val_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [RW-1:0] r_in;
    len_t          root_in;
    wide_t         v_in;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic [RW+1:0] dif;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in    = '0;
      assign root_in = '0;
      assign v_in    = val_i;
    end else begin : g_next
      assign r_in    = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign v_in    = val_q[k-1];
    end

    assign cur   = {r_in, v_in[DW-1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    assign ge    = cur >= trial;
    assign dif   = cur - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? dif[RW-1:0] : cur[RW-1:0];
        root_q[k] <= {root_in[CW-2:0], ge};
        val_q[k]  <= v_in << 2;
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];
endmodule

// ----- hw/rtl/lvds_obuf.sv -----
// ----------------------------------------------------------------------------
// lvds_obuf
// two-entry result buffer between the pipeline and the result channel
// ----------------------------------------------------------------------------
module lvds_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lvds_pkg::res_t data_i,
  output logic           full_o,
  lvds_res_if.source     res_o
);
  import lvds_pkg::*;

  res_t       ent_q [2];
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       pop;

  assign pop   = res_o.valid && res_o.ready;
  assign cnt_d = 2'(cnt_q + {1'b0, push_i} - {1'b0, pop});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push_i && cnt_q == 2'd2) begin
        ent_q[0] <= ent_q[1];
        ent_q[1] <= data_i;
      end else if (push_i) begin
        ent_q[0] <= data_i;
      end else begin
        ent_q[0] <= ent_q[1];
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        ent_q[0] <= data_i;
      end else begin
        ent_q[1] <= data_i;
      end
    end
  end

  assign full_o              = cnt_q == 2'd2;
  assign res_o.valid         = cnt_q != 2'd0;
  assign res_o.scene_x       = ent_q[0].scene_x;
  assign res_o.scene_y       = ent_q[0].scene_y;
  assign res_o.scene_z       = ent_q[0].scene_z;
  assign res_o.scene_dist    = ent_q[0].scene_dist;
  assign res_o.scale_factor  = ent_q[0].scale_factor;
  assign res_o.obs_distance  = ent_q[0].obs_distance;
  assign res_o.apparent_size = ent_q[0].apparent_size;
  assign res_o.is_resolved   = ent_q[0].is_resolved;
endmodule

// ----- hw/rtl/leaf_visibility_depth_scaling_top.sv -----
// ----------------------------------------------------------------------------
// leaf_visibility_depth_scaling_top
// camera-relative distance, apparent size and depth-scaled scene placement
// ----------------------------------------------------------------------------
// One object transaction enters per clock and one result transaction leaves
// per clock in steady state, while the result channel keeps taking results.
// From acceptance to the result buffer each object passes a 48-stage square
// root and three 64-stage restoring dividers in series: distance and size,
// the inverse-law term mid*mid/r, and the final rescale by distance, with
// two-stage multipliers between them. The whole pipeline advances together
// and halts only when the two-entry result buffer is full, so one finished
// result may wait while new objects keep coming. Configuration registers are
// read live by the pipeline and must only be written while it is empty.
`include "assert_macros.svh"

module leaf_visibility_depth_scaling_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [lvds_pkg::CW-1:0] cfg_data_i,
  lvds_obj_if.sink              obj_i,
  lvds_res_if.source            res_o
);
  import lvds_pkg::*;

  // stage counts along the pipe
  localparam int S1_N = MUL_LAT + 1 + SQRT_STEPS + MUL_LAT + 1;
  localparam int LAT  = S1_N + DIV_STEPS + 1 + DIV_STEPS + 1 + MUL_LAT + DIV_STEPS;

  localparam logic signed [CW:0] SPOS = {2'b00, {(CW-1){1'b1}}};
  localparam logic signed [CW:0] SNEG = {2'b11, {(CW-1){1'b0}}};
  localparam quo_t               ONE_SF = quo_t'(1) << CW;  // 1.0 scaled for 2^48/s

  // payload carried beside the units
  typedef struct packed {
    logic [2:0]     neg;
    len_t [2:0]     mag;
    len_t           ext;
  } s1_t;

  typedef struct packed {
    logic [2:0]     neg;
    len_t [2:0]     mag;
    len_t           odist;
    logic           a_ovf;
    logic           dz;
  } s2_t;

  typedef struct packed {
    logic [2:0]     neg;
    len_t [2:0]     mag;
    len_t           odist;
    logic           inv;
    len_t           size;
    logic           res;
    len_t [2:0]     lin_pos;
    len_t           lin_dist;
    len_t           lin_sf;
  } s3_t;

  typedef struct packed {
    s3_t            b;
    len_t           sdc;
    logic           h_ovf;
  } s5_t;

  // configuration registers
  len_t cam_q [3];
  len_t pa_q;
  len_t min_q;
  len_t mid_q;
  len_t scl_q;
  logic dep_q;
  len_t s_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
      pa_q     <= len_t'(4294967);
      min_q    <= len_t'(65536);
      mid_q    <= len_t'(65536);
      scl_q    <= len_t'(65536);
      dep_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CAM_X:       cam_q[0] <= cfg_data_i;
        CFG_CAM_Y:       cam_q[1] <= cfg_data_i;
        CFG_CAM_Z:       cam_q[2] <= cfg_data_i;
        CFG_PIX_ANGLE:   pa_q     <= cfg_data_i;
        CFG_MIN_SIZE:    min_q    <= cfg_data_i;
        CFG_MID_PLANE:   mid_q    <= cfg_data_i;
        CFG_SCENE_SCALE: scl_q    <= cfg_data_i;
        CFG_DEPTH_ON:    dep_q    <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  // zero scale acts as the smallest step
  assign s_eff = (scl_q == '0) ? len_t'(1) : scl_q;

  // global advance: the pipe moves unless the result buffer is full
  logic         adv;
  logic         obuf_full;
  logic [LAT:1] v_q;

  assign adv         = ~obuf_full;
  assign obj_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAT-1:1], obj_i.valid};
    end
  end

  // camera-relative vector, saturated, split into sign and magnitude
  len_t              obj_pos [3];
  logic signed [CW:0] ds_c;
  logic signed [CW:0] mg_c;
  s1_t               s1_d;
  s1_t               s1_q [S1_N];

  assign obj_pos[0] = obj_i.obj_x;
  assign obj_pos[1] = obj_i.obj_y;
  assign obj_pos[2] = obj_i.obj_z;

  always_comb begin
    s1_d     = '0;
    ds_c     = '0;
    mg_c     = '0;
    for (int i = 0; i < 3; i++) begin
      ds_c = $signed({obj_pos[i][CW-1], obj_pos[i]}) - $signed({cam_q[i][CW-1], cam_q[i]});
      if (ds_c > SPOS) begin
        ds_c = SPOS;
      end else if (ds_c < SNEG) begin
        ds_c = SNEG;
      end
      mg_c          = ds_c[CW] ? -ds_c : ds_c;
      s1_d.neg[i]   = ds_c[CW];
      s1_d.mag[i]   = mg_c[CW-1:0];
    end
    s1_d.ext = obj_i.obj_extent;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q[0] <= s1_d;
      for (int k = 1; k < S1_N; k++) begin
        s1_q[k] <= s1_q[k-1];
      end
    end
  end

  // squared magnitudes and their sum
  wide_t sq [3];
  wide_t sum_q;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    lvds_mul u_sq (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (s1_q[0].mag[i]),
      .b_i   (s1_q[0].mag[i]),
      .p_o   (sq[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= sq[0] + sq[1] + sq[2];
    end
  end

  // observer distance
  len_t root;
  len_t dd_q [2];
  wide_t den;

  lvds_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .val_i  (sum_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= root;
      dd_q[1] <= dd_q[0];
    end
  end

  // distance times pixel angle
  lvds_mul u_den (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (root),
    .b_i   (pa_q),
    .p_o   (den)
  );

  // first divider bank: size, reduced distance, linear mapping
  s1_t  l1;
  s2_t  s2_d;
  s2_t  s2_q [DIV_STEPS];
  quo_t q_a;
  quo_t q_b;
  quo_t q_d;
  quo_t q_c [3];

  assign l1 = s1_q[S1_N-1];

  always_comb begin
    s2_d       = '0;
    s2_d.neg   = l1.neg;
    s2_d.mag   = l1.mag;
    s2_d.odist = dd_q[1];
    // quotient reaches 2^48 exactly when extent is not below the divisor
    s2_d.a_ovf = DW'(l1.ext) >= den;
    s2_d.dz    = dd_q[1] == '0;
  end

  lvds_div u_div_a (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rem_i  (DW'(l1.ext[CW-1:16])),
    .tail_i ({l1.ext[15:0], {CW{1'b0}}}),
    .div_i  (den),
    .quo_o  (q_a)
  );

  lvds_div u_div_b (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rem_i  ('0),
    .tail_i ({dd_q[1], 16'b0}),
    .div_i  (DW'(s_eff)),
    .quo_o  (q_b)
  );

  lvds_div u_div_d (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rem_i  ('0),
    .tail_i (ONE_SF),
    .div_i  (DW'(s_eff)),
    .quo_o  (q_d)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lin
    lvds_div u_div_c (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  ('0),
      .tail_i ({l1.mag[i], 16'b0}),
      .div_i  (DW'(s_eff)),
      .quo_o  (q_c[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q[0] <= s2_d;
      for (int k = 1; k < DIV_STEPS; k++) begin
        s2_q[k] <= s2_q[k-1];
      end
    end
  end

  // size, resolve flag, linear results, mapping choice
  s2_t  l2;
  s3_t  s3_d;
  s3_t  s3_q [DIV_STEPS+1];
  quo_t r_q;

  assign l2 = s2_q[DIV_STEPS-1];

  always_comb begin
    s3_d       = '0;
    s3_d.neg   = l2.neg;
    s3_d.mag   = l2.mag;
    s3_d.odist = l2.odist;
    // zero distance: no size, always resolved
    if (l2.dz) begin
      s3_d.size = '0;
    end else if (l2.a_ovf) begin
      s3_d.size = UMAX;
    end else begin
      s3_d.size = q_a[CW-1:0];
    end
    s3_d.res  = l2.dz || (s3_d.size > min_q);
    s3_d.inv  = dep_q && (q_b > QW'(mid_q));
    for (int i = 0; i < 3; i++) begin
      s3_d.lin_pos[i] = sout(l2.neg[i], q_c[i]);
    end
    s3_d.lin_dist = usat(q_b);
    s3_d.lin_sf   = usat(q_d);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q     <= q_b;
      s3_q[0] <= s3_d;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        s3_q[k] <= s3_q[k-1];
      end
    end
  end

  // inverse law: mid*mid / r, mid squared runs freely off the register
  wide_t mm;
  quo_t  q_e;

  lvds_mul u_mm (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .a_i   (mid_q),
    .b_i   (mid_q),
    .p_o   (mm)
  );

  lvds_div u_div_e (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rem_i  (DW'(mm[DW-1:QW])),
    .tail_i (mm[QW-1:0]),
    .div_i  (DW'(r_q)),
    .quo_o  (q_e)
  );

  // compressed distance 2m - m*m/r, saturated
  logic [QW:0] sdw;
  len_t        sdc_d;
  len_t        sdc_q [3];
  s3_t         s4_q  [3];

  assign sdw   = (QW+1)'({mid_q, 1'b0}) - {1'b0, q_e};
  assign sdc_d = (sdw > (QW+1)'(UMAX)) ? UMAX : sdw[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sdc_q[0] <= sdc_d;
      sdc_q[1] <= sdc_q[0];
      sdc_q[2] <= sdc_q[1];
      s4_q[0]  <= s3_q[DIV_STEPS];
      s4_q[1]  <= s4_q[0];
      s4_q[2]  <= s4_q[1];
    end
  end

  // second divider bank: inverse positions and scale factor
  wide_t gp [3];
  quo_t  q_g [3];
  quo_t  q_h;
  s5_t   s5_d;
  s5_t   s5_q [DIV_STEPS];

  for (genvar i = 0; i < 3; i++) begin : g_inv
    lvds_mul u_gp (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (s4_q[0].mag[i]),
      .b_i   (sdc_q[0]),
      .p_o   (gp[i])
    );

    lvds_div u_div_g (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (DW'(gp[i][DW-1:QW])),
      .tail_i (gp[i][QW-1:0]),
      .div_i  (DW'(s4_q[2].odist)),
      .quo_o  (q_g[i])
    );
  end

  lvds_div u_div_h (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rem_i  (DW'(sdc_q[2][CW-1:32])),
    .tail_i ({sdc_q[2][31:0], 32'b0}),
    .div_i  (DW'(s4_q[2].odist)),
    .quo_o  (q_h)
  );

  always_comb begin
    s5_d       = '0;
    s5_d.b     = s4_q[2];
    s5_d.sdc   = sdc_q[2];
    // scale factor overflows when sd reaches distance times 2^16
    s5_d.h_ovf = QW'(sdc_q[2]) >= {s4_q[2].odist, 16'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q[0] <= s5_d;
      for (int k = 1; k < DIV_STEPS; k++) begin
        s5_q[k] <= s5_q[k-1];
      end
    end
  end

  // final selection between linear and inverse mapping
  s5_t  l5;
  res_t res_d;
  len_t pos_sel [3];

  assign l5 = s5_q[DIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_sel[i] = l5.b.inv ? sout(l5.b.neg[i], q_g[i]) : l5.b.lin_pos[i];
    end
    res_d.scene_x       = pos_sel[0];
    res_d.scene_y       = pos_sel[1];
    res_d.scene_z       = pos_sel[2];
    res_d.scene_dist    = l5.b.inv ? l5.sdc : l5.b.lin_dist;
    if (!l5.b.inv) begin
      res_d.scale_factor = l5.b.lin_sf;
    end else if (l5.h_ovf) begin
      res_d.scale_factor = UMAX;
    end else begin
      res_d.scale_factor = q_h[CW-1:0];
    end
    res_d.obs_distance  = l5.b.odist;
    res_d.apparent_size = l5.b.size;
    res_d.is_resolved   = l5.b.res;
  end

  lvds_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv && v_q[LAT]),
    .data_i (res_d),
    .full_o (obuf_full),
    .res_o  (res_o)
  );

  // an accepted transaction always enters the first valid stage
  `LVDS_ASSERT(a_accept_tracked, (obj_i.valid && obj_i.ready) |=> v_q[1], "accepted object lost")
  // a halted pipe keeps every valid bit in place
  `LVDS_ASSERT(a_halt_holds, !adv |=> $stable(v_q), "valid bits moved while halted")
  // zero distance gives zero size and a resolved object
  `LVDS_ASSERT(a_zero_dist, (res_o.valid && res_o.obs_distance == '0) |-> (res_o.is_resolved && res_o.apparent_size == '0), "zero distance result wrong")

endmodule

// ----- sim/tb_leaf_visibility_depth_scaling_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_leaf_visibility_depth_scaling_top
// Stream test of the leaf visibility block. Object transactions go in from a
// pending queue, and a bit-exact software copy of the datapath predicts each
// result. Results are compared field by field with the oldest prediction.
// Both sides stall at random. The camera and scaling registers change only
// between phases, while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_leaf_visibility_depth_scaling_top;
  import lvds_pkg::*;

  localparam int         HALF_PERIOD = 2;
  localparam int         LATENCY     = 260;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [47:0] SIGN_MIN   = 48'h8000_0000_0000;

  typedef struct {
    logic [47:0] x;
    logic [47:0] y;
    logic [47:0] z;
    logic [47:0] ext;
  } obj_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;

  lvds_obj_if obj_if ();
  lvds_res_if res_if ();

  leaf_visibility_depth_scaling_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .obj_i     (obj_if),
    .res_o     (res_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // shadow copy of the configuration registers
  logic [47:0] cam_x, cam_y, cam_z, pix_angle, min_sz, mid_pl, scn_scale;
  logic        depth_on;

  obj_item_t pending_objs[$];
  res_t      expected_res[$];
  obj_item_t cur_obj;
  logic      no_idle = 1'b0;
  int        errors = 0;
  int        cycles = 0;
  int        results_seen = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;

  // ---------------------------------------------------------------------------
  // datapath prediction, mostly in wide unsigned arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] sat_u(logic [127:0] v, logic [47:0] lim);
    return (v > {80'b0, lim}) ? lim : v[47:0];
  endfunction

  function automatic logic [47:0] sat_s(logic neg, logic [127:0] q);
    logic [47:0] lim;
    logic [47:0] v;
    lim = neg ? SIGN_MIN : SMAX;
    v = sat_u(q, lim);
    return neg ? (48'(0) - v) : v;
  endfunction

  function automatic res_t predict_leaf(obj_item_t it);
    logic [47:0]        pos[3];
    logic [47:0]        cam[3];
    logic [47:0]        mag[3];
    logic               neg[3];
    logic signed [63:0] d;
    logic [127:0]       sum, den, r, sd, t2;
    logic [63:0]        root, t;
    logic [47:0]        odist, size, s, sdc;
    res_t               o;
    pos[0] = it.x; pos[1] = it.y; pos[2] = it.z;
    cam[0] = cam_x; cam[1] = cam_y; cam[2] = cam_z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = $signed({{16{pos[i][47]}}, pos[i]}) - $signed({{16{cam[i][47]}}, cam[i]});
      // camera-relative component saturates to the signed length range
      if (d > $signed({16'b0, SMAX})) d = $signed({16'b0, SMAX});
      if (d < -$signed({16'b0, SIGN_MIN})) d = -$signed({16'b0, SIGN_MIN});
      neg[i] = d < 0;
      mag[i] = neg[i] ? 48'(-d) : 48'(d);
      sum += {80'b0, mag[i]} * {80'b0, mag[i]};
    end
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      t = root | (64'd1 << b);
      t2 = {64'b0, t} * {64'b0, t};
      if (t2 <= sum) root = t;
    end
    odist = root[47:0];
    if (odist == '0) begin
      size = '0;
      o.is_resolved = 1'b1;
    end else begin
      den = {80'b0, odist} * {80'b0, pix_angle};
      size = (den == '0) ? UMAX : sat_u(({80'b0, it.ext} << 48) / den, UMAX);
      o.is_resolved = size > min_sz;
    end
    s = (scn_scale == '0) ? 48'd1 : scn_scale;
    r = ({80'b0, odist} << 16) / {80'b0, s};
    if (!depth_on || r <= {80'b0, mid_pl}) begin
      o.scene_x = sat_s(neg[0], ({80'b0, mag[0]} << 16) / {80'b0, s});
      o.scene_y = sat_s(neg[1], ({80'b0, mag[1]} << 16) / {80'b0, s});
      o.scene_z = sat_s(neg[2], ({80'b0, mag[2]} << 16) / {80'b0, s});
      o.scene_dist = sat_u(r, UMAX);
      o.scale_factor = sat_u((128'd1 << 48) / {80'b0, s}, UMAX);
    end else begin
      // inverse law beyond the mid plane
      sd = ({80'b0, mid_pl} << 1) - (({80'b0, mid_pl} * {80'b0, mid_pl}) / r);
      sdc = sat_u(sd, UMAX);
      o.scene_x = sat_s(neg[0], ({80'b0, mag[0]} * {80'b0, sdc}) / {80'b0, odist});
      o.scene_y = sat_s(neg[1], ({80'b0, mag[1]} * {80'b0, sdc}) / {80'b0, odist});
      o.scene_z = sat_s(neg[2], ({80'b0, mag[2]} * {80'b0, sdc}) / {80'b0, odist});
      o.scene_dist = sdc;
      o.scale_factor = sat_u(({80'b0, sdc} << 32) / {80'b0, odist}, UMAX);
    end
    o.obs_distance = odist;
    o.apparent_size = size;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: object transactions from the pending queue
  // ---------------------------------------------------------------------------
  initial begin
    obj_if.valid = 1'b0;
    obj_if.obj_x = '0;
    obj_if.obj_y = '0;
    obj_if.obj_z = '0;
    obj_if.obj_extent = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (obj_if.valid && obj_if.ready) expected_res.push_back(predict_leaf(cur_obj));
      if (!obj_if.valid || obj_if.ready) begin
        if (pending_objs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 37)) begin
          cur_obj <= pending_objs[0];
          obj_if.obj_x <= pending_objs[0].x;
          obj_if.obj_y <= pending_objs[0].y;
          obj_if.obj_z <= pending_objs[0].z;
          obj_if.obj_extent <= pending_objs[0].ext;
          void'(pending_objs.pop_front());
          obj_if.valid <= 1'b1;
        end else begin
          obj_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: result transactions against the oldest prediction
  // ---------------------------------------------------------------------------
  initial res_if.ready = 1'b0;

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_res.size() == 0) begin
          $error("result transaction with no prediction pending");
          errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (res_if.scene_x !== exp_r.scene_x) begin
            $error("scene_x expected %h actual %h", exp_r.scene_x, res_if.scene_x);
            errors++;
          end
          if (res_if.scene_y !== exp_r.scene_y) begin
            $error("scene_y expected %h actual %h", exp_r.scene_y, res_if.scene_y);
            errors++;
          end
          if (res_if.scene_z !== exp_r.scene_z) begin
            $error("scene_z expected %h actual %h", exp_r.scene_z, res_if.scene_z);
            errors++;
          end
          if (res_if.scene_dist !== exp_r.scene_dist) begin
            $error("scene_dist expected %h actual %h", exp_r.scene_dist, res_if.scene_dist);
            errors++;
          end
          if (res_if.scale_factor !== exp_r.scale_factor) begin
            $error("scale_factor expected %h actual %h",
                   exp_r.scale_factor, res_if.scale_factor);
            errors++;
          end
          if (res_if.obs_distance !== exp_r.obs_distance) begin
            $error("obs_distance expected %h actual %h",
                   exp_r.obs_distance, res_if.obs_distance);
            errors++;
          end
          if (res_if.apparent_size !== exp_r.apparent_size) begin
            $error("apparent_size expected %h actual %h",
                   exp_r.apparent_size, res_if.apparent_size);
            errors++;
          end
          if (res_if.is_resolved !== exp_r.is_resolved) begin
            $error("is_resolved expected %b actual %b", exp_r.is_resolved, res_if.is_resolved);
            errors++;
          end
        end
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (!hold_done && results_seen >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 700;
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // random value of random width, so small and large magnitudes both show up
  function automatic logic [47:0] rand_width();
    int w;
    w = $urandom_range(1, 48);
    return rand48() & ((48'd1 << w) - 48'd1 | (w == 48 ? UMAX : 48'd0));
  endfunction

  // signed offset of random width
  function automatic logic [47:0] rand_off();
    logic [47:0] v;
    v = rand_width() >> $urandom_range(0, 40);
    return $urandom_range(0, 1) ? (48'(0) - v) : v;
  endfunction

  function automatic obj_item_t rand_obj();
    obj_item_t it;
    case ($urandom_range(0, 9))
      0, 1: begin
        it.x = rand48(); it.y = rand48(); it.z = rand48();
      end
      2: begin
        it.x = $urandom_range(0, 1) ? SMAX : SIGN_MIN;
        it.y = $urandom_range(0, 1) ? SMAX : rand48();
        it.z = $urandom_range(0, 1) ? SIGN_MIN : rand48();
      end
      default: begin
        // near the camera, where size and depth compression vary most
        it.x = cam_x + rand_off();
        it.y = cam_y + rand_off();
        it.z = cam_z + rand_off();
      end
    endcase
    it.ext = $urandom_range(0, 15) == 0 ? ($urandom_range(0, 1) ? UMAX : '0) : rand_width();
    return it;
  endfunction

  function automatic obj_item_t mk_obj(logic [47:0] x, logic [47:0] y, logic [47:0] z,
                                       logic [47:0] e);
    obj_item_t it;
    it.x = x; it.y = y; it.z = z; it.ext = e;
    return it;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_CAM_X:       cam_x = val;
      CFG_CAM_Y:       cam_y = val;
      CFG_CAM_Z:       cam_z = val;
      CFG_PIX_ANGLE:   pix_angle = val;
      CFG_MIN_SIZE:    min_sz = val;
      CFG_MID_PLANE:   mid_pl = val;
      CFG_SCENE_SCALE: scn_scale = val;
      CFG_DEPTH_ON:    depth_on = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [47:0] cx, logic [47:0] cy, logic [47:0] cz,
                           logic [47:0] pa, logic [47:0] ms, logic [47:0] mp,
                           logic [47:0] ss, logic dp);
    write_reg(CFG_CAM_X, cx);
    write_reg(CFG_CAM_Y, cy);
    write_reg(CFG_CAM_Z, cz);
    write_reg(CFG_PIX_ANGLE, pa);
    write_reg(CFG_MIN_SIZE, ms);
    write_reg(CFG_MID_PLANE, mp);
    write_reg(CFG_SCENE_SCALE, ss);
    write_reg(CFG_DEPTH_ON, {47'b0, dp});
  endtask

  // wait for every prediction to be matched, then let the pipeline settle
  task automatic drain();
    while (pending_objs.size() > 0 || obj_if.valid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_objs.push_back(rand_obj());
  endtask

  initial begin
    // reset values of the register file
    cam_x = '0; cam_y = '0; cam_z = '0;
    pix_angle = 48'd4294967; min_sz = 48'd65536; mid_pl = 48'd65536;
    scn_scale = 48'd65536; depth_on = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed objects at reset configuration
    pending_objs.push_back(mk_obj('0, '0, '0, '0));             // zero distance
    pending_objs.push_back(mk_obj('0, '0, '0, UMAX));
    pending_objs.push_back(mk_obj(48'h1_0000, '0, '0, 48'h1_0000));  // on the mid plane
    pending_objs.push_back(mk_obj(48'h8000, '0, '0, 48'h1_0000));    // inside mid plane
    pending_objs.push_back(mk_obj(48'h2_0000, 48'h3_0000, '0, 48'h100));
    pending_objs.push_back(mk_obj(SMAX, SMAX, SMAX, UMAX));
    pending_objs.push_back(mk_obj(SIGN_MIN, SIGN_MIN, SIGN_MIN, UMAX));
    pending_objs.push_back(mk_obj(SMAX, SIGN_MIN, '0, '0));
    pending_objs.push_back(mk_obj(48'hFFFF_FFFF_FFFF, '0, 48'h1, 48'h1));
    pending_objs.push_back(mk_obj('0, 48'h64_0000, '0, 48'h1));      // tiny, not resolved
    pending_objs.push_back(mk_obj('0, '0, 48'h10_0000_0000, UMAX));
    drain();

    // camera at the top corner; differences saturate; depth off; smallest steps
    write_all(SMAX, SMAX, SMAX, UMAX, '0, '0, 48'd1, 1'b0);
    pending_objs.push_back(mk_obj(SIGN_MIN, SIGN_MIN, SIGN_MIN, UMAX));
    pending_objs.push_back(mk_obj(SMAX, SMAX, SMAX, UMAX));
    pending_objs.push_back(mk_obj(SMAX - 1, SMAX, SMAX, 48'd1));
    queue_random(180);
    drain();

    // camera at the bottom corner; zero pixel angle and zero scene scale
    write_all(SIGN_MIN, SIGN_MIN, SIGN_MIN, '0, UMAX, UMAX, '0, 1'b1);
    pending_objs.push_back(mk_obj(SMAX, SMAX, SMAX, UMAX));
    pending_objs.push_back(mk_obj(SIGN_MIN, SIGN_MIN, SIGN_MIN, '0));
    pending_objs.push_back(mk_obj(SIGN_MIN + 1, SIGN_MIN, SIGN_MIN, '0));
    queue_random(180);
    drain();

    // zero mid plane with depth on: every nonzero distance compresses
    write_all('0, '0, '0, 48'd4294967, '0, '0, 48'd65536, 1'b1);
    pending_objs.push_back(mk_obj(48'h1, '0, '0, 48'h1));
    queue_random(180);
    drain();

    // a stretch with no idling on either side
    no_idle <= 1'b1;
    write_all(rand48(), rand48(), rand48(), rand48(), rand_width(), rand_width(),
              rand_width() | 48'd1, 1'b1);
    queue_random(200);
    drain();
    no_idle <= 1'b0;

    // random settings
    for (int p = 0; p < 5; p++) begin
      write_all(rand48(), rand48(), rand48(), rand_width(), rand_width(), rand_width(),
                rand_width(), 1'(($urandom_range(0, 3)) != 0));
      queue_random(180);
      drain();
    end

    if (errors == 0 && expected_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
